// ----- rtl/smpq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_pkg
// shared types and constants of the stable min priority queue
// ----------------------------------------------------------------------------
package smpq_pkg;

  localparam int unsigned QueueDepth = 64;
  localparam int unsigned AddrBits   = $clog2(QueueDepth);
  localparam int unsigned CountBits  = $clog2(QueueDepth + 1);
  localparam int unsigned PrioBits   = 8;
  localparam int unsigned StampBits  = 32;

  localparam logic [1:0] StPushOk   = 2'd0;
  localparam logic [1:0] StPushFull = 2'd1;
  localparam logic [1:0] StPopOk    = 2'd2;
  localparam logic [1:0] StPopEmpty = 2'd3;

  localparam logic FuncPush = 1'b0;
  localparam logic FuncPop  = 1'b1;

  typedef struct packed {
    logic [PrioBits-1:0]  prio;
    logic [StampBits-1:0] stamp;
    logic [15:0]          record_id;
    logic [6:0]           age;
    logic [7:0]           sex_code;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_LAST  = 5'b00100,
    S_MOVE  = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

endpackage

// ----- rtl/stable_min_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_min_priority_queue
// bounded min priority queue with fifo order among equal priorities
// ----------------------------------------------------------------------------
//  channel  | dir | tuser  | tdata fields (lsb first)
//  s_axis   | in  | func   | entry_priority, record_id, age, sex_code (pad 0)
//  m_axis   | out | status | out_priority, out_record_id, out_age,
//           |     |        | out_sex_code, fill_level (pad 0)
//
//  push, full push, empty pop: result valid the cycle after the transfer;
//  s_axis_tready stays low until the result is taken
//  pop: the single read port scans the held entries one a cycle, then the
//  last entry moves into the hole; s_axis_tready stays low until the
//  result is taken
//  reset clears count, arrival counter and control; entries are not cleared
// ----------------------------------------------------------------------------
module stable_min_priority_queue
  import smpq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // func
  input  logic        s_axis_tuser,
  // entry_priority, record_id, age, sex_code, zero pad
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status
  output logic [1:0]  m_axis_tuser,
  // out_priority, out_record_id, out_age, out_sex_code, fill_level, zero pad
  output logic [47:0] m_axis_tdata
);

  // entry memory, one read port registered
  entry_t mem_q [QueueDepth];
  entry_t rd_q;
  logic   we;
  logic [AddrBits-1:0] wa, ra;
  entry_t wd;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rd_q <= mem_q[ra];
  end

  state_e state_q, state_d;
  logic [CountBits-1:0] count_q, count_d;
  logic [StampBits-1:0] arr_q, arr_d;
  logic [CountBits-1:0] idx_q, idx_d;     // next address issued
  logic [AddrBits-1:0]  best_q, best_d;
  entry_t best_e_q, best_e_d;
  logic [CountBits-1:0] cmp_q, cmp_d;     // index of the word in rd_q
  logic                 have_q, have_d;
  logic [49:0] out_q, out_d;              // status in the low two bits
  logic        ov_q, ov_d;

  logic       in_func;
  assign in_func = s_axis_tuser;

  // true when the freshly read entry leaves before the current best
  logic rd_first;
  logic [StampBits-1:0] age_rd, age_best;
  assign age_rd   = arr_q - rd_q.stamp;
  assign age_best = arr_q - best_e_q.stamp;
  assign rd_first = (rd_q.prio != best_e_q.prio) ? (rd_q.prio < best_e_q.prio)
                                                 : (age_rd > age_best);

  function automatic logic [49:0] pack_out(logic [1:0] st, entry_t e,
                                           logic [CountBits-1:0] lvl);
    pack_out = {2'd0, lvl, e.sex_code, e.age, e.record_id, e.prio, st};
  endfunction

  assign s_axis_tready = (state_q == S_IDLE) && !ov_q;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    arr_d    = arr_q;
    idx_d    = idx_q;
    best_d   = best_q;
    best_e_d = best_e_q;
    cmp_d    = cmp_q;
    have_d   = have_q;
    out_d    = out_q;
    ov_d     = ov_q;
    we = 1'b0;
    wa = '0;
    wd = '0;
    ra = idx_q[AddrBits-1:0];
    if (ov_q && m_axis_tready) ov_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          if (in_func == FuncPush) begin
            if (count_q >= CountBits'(QueueDepth)) begin
              out_d = pack_out(StPushFull, '0, count_q);
            end else begin
              we = 1'b1;
              wa = count_q[AddrBits-1:0];
              wd.prio = s_axis_tdata[7:0];
              wd.stamp = arr_q;
              wd.record_id = s_axis_tdata[23:8];
              wd.age = s_axis_tdata[30:24];
              wd.sex_code = s_axis_tdata[38:31];
              arr_d = arr_q + 1'b1;
              count_d = count_q + 1'b1;
              out_d = pack_out(StPushOk, '0, count_q + 1'b1);
            end
            ov_d = 1'b1;
          end else if (count_q == '0) begin
            out_d = pack_out(StPopEmpty, '0, count_q);
            ov_d = 1'b1;
          end else begin
            ra = '0;
            idx_d = CountBits'(1);
            cmp_d = '0;
            have_d = 1'b0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // rd_q holds entry cmp_q
        if (!have_q || rd_first) begin
          best_e_d = rd_q;
          best_d = cmp_q[AddrBits-1:0];
        end
        have_d = 1'b1;
        cmp_d = idx_q;
        if (idx_q == count_q) begin
          ra = AddrBits'(count_q - 1'b1);
          state_d = S_LAST;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_LAST: begin
        // rd_q holds the last entry; best is final; keep the last entry on the port
        ra = AddrBits'(count_q - 1'b1);
        state_d = S_MOVE;
      end
      S_MOVE: begin
        we = 1'b1;
        wa = best_q;
        wd = rd_q;
        count_d = count_q - 1'b1;
        out_d = pack_out(StPopOk, best_e_q, count_q - 1'b1);
        ov_d = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      arr_q   <= '0;
      idx_q   <= '0;
      cmp_q   <= '0;
      have_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      arr_q   <= arr_d;
      idx_q   <= idx_d;
      cmp_q   <= cmp_d;
      have_q  <= have_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q   <= best_d;
    best_e_q <= best_e_d;
    out_q    <= out_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = out_q[1:0];
  assign m_axis_tdata  = out_q[49:2];

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountBits'(QueueDepth)) else $error("count overflow");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !s_axis_tready) else $error("accept while busy");
  a_move_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOVE) |=> ov_q) else $error("pop without result");
  a_best_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOVE) |-> (CountBits'(best_q) < count_q))
    else $error("best out of range");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the stable min priority queue: a queue-fed stream
// driver and a stream monitor compare every result transfer against a
// scoreboard that picks held records by priority, then arrival order
// ----------------------------------------------------------------------------
module testbench;
  import smpq_pkg::*;

  localparam int unsigned NumRandom = 1600;
  localparam int unsigned QuietTail = 200;

  // one result transfer as predicted
  typedef struct {
    logic [1:0]  status;
    logic [7:0]  prio;
    logic [15:0] record_id;
    logic [6:0]  age;
    logic [7:0]  sex_code;
    logic [6:0]  fill;
  } result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // func
  logic        s_axis_tuser;
  // entry_priority, record_id, age, sex_code, zero pad
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // status
  logic [1:0]  m_axis_tuser;
  // out_priority, out_record_id, out_age, out_sex_code, fill_level, zero pad
  logic [47:0] m_axis_tdata;

  stable_min_priority_queue i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
  );

  // items waiting to be offered and results waiting to arrive
  // item layout, lsb first: func, priority, record id, age, sex code, pad
  logic [40:0] pending_items[$];
  result_t     awaited_results[$];
  logic [40:0] drv_item;

  // shadow copy of the held records
  logic [7:0]  held_prio[QueueDepth];
  logic [31:0] held_stamp[QueueDepth];
  logic [15:0] held_id[QueueDepth];
  logic [6:0]  held_age[QueueDepth];
  logic [7:0]  held_sex[QueueDepth];
  int unsigned held_count;
  logic [31:0] next_stamp;

  int unsigned errors;
  int unsigned results_seen;
  int unsigned n_push, n_full, n_pop, n_empty, max_fill;
  bit          quiet;
  bit          held_off;
  int unsigned drv_gap;
  int unsigned mon_gap;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // true when held record a leaves before held record b
  function automatic bit leaves_first(int unsigned a, int unsigned b);
    if (held_prio[a] != held_prio[b]) return held_prio[a] < held_prio[b];
    // older arrival wins, measured modulo the stamp width so a wrap keeps order
    return (next_stamp - held_stamp[a]) > (next_stamp - held_stamp[b]);
  endfunction

  // apply one accepted item to the shadow queue and queue up its result
  task automatic predict_item(input logic [40:0] item);
    result_t     res;
    int unsigned best;
    int unsigned last;
    res = '{default: '0};
    if (item[0] == FuncPush) begin
      if (held_count >= QueueDepth) begin
        res.status = StPushFull;
        n_full++;
      end else begin
        held_prio[held_count]  = item[8:1];
        held_stamp[held_count] = next_stamp;
        held_id[held_count]    = item[24:9];
        held_age[held_count]   = item[31:25];
        held_sex[held_count]   = item[39:32];
        next_stamp++;
        held_count++;
        res.status = StPushOk;
        n_push++;
      end
    end else begin
      if (held_count == 0) begin
        res.status = StPopEmpty;
        n_empty++;
      end else begin
        best = 0;
        for (int unsigned i = 1; i < held_count; i++)
          if (leaves_first(i, best)) best = i;
        res.prio      = held_prio[best];
        res.record_id = held_id[best];
        res.age       = held_age[best];
        res.sex_code  = held_sex[best];
        // last entry fills the hole
        last = held_count - 1;
        held_prio[best]  = held_prio[last];
        held_stamp[best] = held_stamp[last];
        held_id[best]    = held_id[last];
        held_age[best]   = held_age[last];
        held_sex[best]   = held_sex[last];
        held_count = last;
        res.status = StPopOk;
        n_pop++;
      end
    end
    if (held_count > max_fill) max_fill = held_count;
    res.fill = held_count[6:0];
    awaited_results.insert(awaited_results.size(), res);
  endtask

  function automatic logic [40:0] pack_item(logic func, logic [7:0] prio,
                                            logic [15:0] id, logic [6:0] age,
                                            logic [7:0] sex);
    return {1'b0, sex, age, id, prio, func};
  endfunction

  // append one item to the driver queue
  task automatic queue_item(input logic [40:0] item);
    pending_items.insert(pending_items.size(), item);
  endtask

  // driver: offers pending items, holds each until its transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tuser  <= 1'b0;
      s_axis_tdata  <= '0;
      drv_gap       <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (drv_gap > 0) begin
        drv_gap       <= drv_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_items.size() > 0 && !quiet && $urandom_range(0, 7) == 0) begin
        // random idle burst
        drv_gap       <= $urandom_range(0, 5);
        s_axis_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        // prediction in offer order equals transfer order
        drv_item = pending_items.pop_front();
        predict_item(drv_item);
        s_axis_tuser  <= drv_item[0];
        s_axis_tdata  <= drv_item[40:1];
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor: checks every result transfer, stalls the result side at random
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      mon_gap       <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status    = m_axis_tuser;
        got.prio      = m_axis_tdata[7:0];
        got.record_id = m_axis_tdata[23:8];
        got.age       = m_axis_tdata[30:24];
        got.sex_code  = m_axis_tdata[38:31];
        got.fill      = m_axis_tdata[45:39];
        results_seen++;
        if (awaited_results.size() == 0) begin
          $error("unexpected result transfer %h", m_axis_tdata);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
          end
          if (got.prio !== want.prio) begin
            $error("out_priority: expected %0d, got %0d", want.prio, got.prio);
            errors++;
          end
          if (got.record_id !== want.record_id) begin
            $error("out_record_id: expected %0d, got %0d", want.record_id,
                   got.record_id);
            errors++;
          end
          if (got.age !== want.age) begin
            $error("out_age: expected %0d, got %0d", want.age, got.age);
            errors++;
          end
          if (got.sex_code !== want.sex_code) begin
            $error("out_sex_code: expected %0d, got %0d", want.sex_code,
                   got.sex_code);
            errors++;
          end
          if (got.fill !== want.fill) begin
            $error("fill_level: expected %0d, got %0d", want.fill, got.fill);
            errors++;
          end
        end
      end
      if (results_seen == 400 && !held_off) begin
        // long hold-off while the driver keeps offering
        held_off      <= 1'b1;
        mon_gap       <= 300;
        m_axis_tready <= 1'b0;
      end else if (mon_gap > 0) begin
        mon_gap       <= mon_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        mon_gap       <= $urandom_range(0, 5);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // random burst of items, push share given in percent
  task automatic add_random(input int unsigned count, input int unsigned push_pct);
    logic [7:0] prio;
    for (int unsigned i = 0; i < count; i++) begin
      // narrow priorities often, so ties are common
      prio = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
      queue_item(pack_item(
          ($urandom_range(0, 99) < push_pct) ? FuncPush : FuncPop, prio,
          16'($urandom_range(0, 65535)), 7'($urandom_range(0, 127)),
          8'($urandom_range(0, 255))));
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || awaited_results.size() > 0 || s_axis_tvalid)
      @(negedge clk_i);
  endtask

  // stimulus and end of run
  initial begin
    int unsigned pct[4];
    errors = 0; results_seen = 0; quiet = 0; held_off = 0;
    n_push = 0; n_full = 0; n_pop = 0; n_empty = 0; max_fill = 0;
    held_count = 0; next_stamp = '0;
    pct = '{30, 55, 80, 97};
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: pop on empty, field extremes, equal-priority ties
    queue_item(pack_item(FuncPop, 8'd0, 16'd0, 7'd0, 8'd0));
    queue_item(pack_item(FuncPush, 8'd0, 16'h0000, 7'd0, 8'h00));
    queue_item(pack_item(FuncPush, 8'hff, 16'hffff, 7'h7f, 8'hff));
    queue_item(pack_item(FuncPush, 8'd5, 16'd1, 7'd10, 8'h2b));
    queue_item(pack_item(FuncPush, 8'd5, 16'd2, 7'd20, 8'h2d));
    queue_item(pack_item(FuncPush, 8'd5, 16'd3, 7'd30, 8'h2b));
    queue_item(pack_item(FuncPush, 8'hff, 16'h1234, 7'h55, 8'haa));
    queue_item(pack_item(FuncPush, 8'd0, 16'h5555, 7'h2a, 8'h55));
    for (int i = 0; i < 8; i++)
      queue_item(pack_item(FuncPop, 8'hff, 16'hffff, 7'h7f, 8'hff));

    // random: bursts of varied push share, filling and draining the queue
    for (int unsigned blk = 0; blk < 8; blk++) add_random(100, pct[$urandom_range(0, 3)]);
    add_random(100, 97);
    // sender pause until every result is in
    wait_drained();
    for (int unsigned blk = 0; blk < 5; blk++) add_random(100, pct[$urandom_range(0, 3)]);
    wait_drained();
    quiet = 1;
    add_random(QuietTail, 60);
    wait_drained();
    repeat (80) @(posedge clk_i);

    $display("ran %0d results: %0d pushes, %0d rejected full, %0d pops, %0d empty pops",
             results_seen, n_push, n_full, n_pop, n_empty);
    $display("peak fill %0d of %0d entries, with one long result-side stall", max_fill,
             QueueDepth);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("stable_min_priority_queue: match");
    end else begin
      $display("stable_min_priority_queue: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("stable_min_priority_queue: mismatch");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/smpq_pkg.sv
rtl/stable_min_priority_queue.sv
tb/sv/testbench.sv
